// ===== hw/rtl/bdq_pkg.sv =====
// bdq_pkg: shared constants and types of the bounded deque
// no dependencies; used by bdq_ctrl and bounded_deque_with_remove
package bdq_pkg;

	// fixed widths of the transaction fields
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;
	localparam int REQ_W   = 3;

	// defaults for the top level parameters
	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// request codes; the two codes above contains are no-ops
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_REMOVE     = 3'd4,
		REQ_CONTAINS   = 3'd5
	} req_t;

	// one finished result, handed from the sequencer to the output register
	typedef struct packed {
		logic               ok;
		logic [DATA_W-1:0]  value;
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} rsp_t;

endpackage

// ===== hw/rtl/bounded_deque_with_remove.sv =====
// bounded_deque_with_remove: double-ended queue of CAPACITY words with remove and contains
// depends on bdq_pkg and bdq_ctrl (which holds bdq_ram)
//
//  channel   | signals                                   | flow
//  ----------+-------------------------------------------+----------------------------
//  request   | req_valid req_stall req_type data_value   | one transaction per request
//  response  | rsp_valid rsp_stall ok out_value          | one transaction per request
//            | count_now overflow                        |
//
// steps: a push writes in place, a pop reads one entry, contains and a miss walk the entries,
//   remove walks to the match and then shifts the entries behind it; the walk reads the ram one entry a cycle
// reset: arst_n clears the sequencer, front index and count; the store needs no clearing
// the response is held in an output register; while rsp_stall holds it, the next
//   result waits in the sequencer and req_stall stays high
module bounded_deque_with_remove #(
	parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [bdq_pkg::REQ_W-1:0]    req_type,
	input  logic [bdq_pkg::DATA_W-1:0]   data_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         ok,
	output logic [bdq_pkg::DATA_W-1:0]   out_value,
	output logic [bdq_pkg::COUNT_W-1:0]  count_now,
	output logic                         overflow
);

	logic ready, start, emit, rsp_free;
	logic rsp_valid_q;
	bdq_pkg::rsp_t res, rsp_q;

	// request handshake
	assign req_stall = !ready;
	assign start     = req_valid && ready;

	// output register is free when empty or being taken
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	bdq_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.data_value (data_value),
		.rsp_free   (rsp_free),
		.ready      (ready),
		.emit       (emit),
		.res        (res)
	);

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign ok        = rsp_q.ok;
	assign out_value = rsp_q.value;
	assign count_now = rsp_q.count;
	assign overflow  = rsp_q.overflow;

endmodule

// ===== hw/rtl/bdq_ram.sv =====
// bdq_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// bdq_ctrl: sequencer, pointer unit and compare unit of the bounded deque
// depends on bdq_pkg and bdq_ram
module bdq_ctrl #(
	parameter int CAPACITY    = bdq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bdq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bdq_pkg::REQ_W-1:0]  req_type,
	input  logic [bdq_pkg::DATA_W-1:0] data_value,
	input  logic                       rsp_free,
	output logic                       ready,
	output logic                       emit,
	output bdq_pkg::rsp_t              res
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SUM_W  = IDX_W + 1;
	localparam int STEP_W = CNT_W + 1;
	localparam int EW     = (VALUE_WIDTH < bdq_pkg::DATA_W) ? VALUE_WIDTH : bdq_pkg::DATA_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_POP   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_SHIFT = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [bdq_pkg::REQ_W-1:0] kind_q;
	logic [EW-1:0] val_q;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
	logic ok_q, ok_d, ovf_q, ovf_d;
	logic [EW-1:0] taken_q, taken_d;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	logic [IDX_W-1:0] inc_in, inc_out, front_dec, slot_off, slot_out;
	logic [SUM_W-1:0] slot_sum, slot_wrap;
	logic [STEP_W-1:0] step_sum;
	logic full, empty, at_end, hit;
	logic [bdq_pkg::DATA_W+EW-1:0] val_ext;
	logic [bdq_pkg::COUNT_W+CNT_W-1:0] cnt_ext;

	bdq_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// status of the store
	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign cnt_m1 = cnt_q - CNT_W'(1);

	// shared circular increment: front on a pop, read pointer on a walk
	assign inc_in  = (state_q == ST_POP) ? front_q : rd_ptr_q;
	assign inc_out = (inc_in == LAST_SLOT) ? '0 : inc_in + IDX_W'(1);

	// circular decrement of the front for a push at the front
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - IDX_W'(1);

	// slot of the back end: front plus count, or plus count minus one
	assign slot_off  = (kind_q == bdq_pkg::REQ_PUSH_BACK) ? cnt_q[IDX_W-1:0]
	                                                      : cnt_m1[IDX_W-1:0];
	assign slot_sum  = {1'b0, front_q} + {1'b0, slot_off};
	assign slot_wrap = slot_sum - SUM_W'(CAPACITY);
	assign slot_out  = (slot_sum >= SUM_W'(CAPACITY)) ? slot_wrap[IDX_W-1:0]
	                                                  : slot_sum[IDX_W-1:0];

	// walk position test and value compare
	assign step_sum = {1'b0, idx_q}
		+ ((state_q == ST_SHIFT) ? STEP_W'(2) : STEP_W'(1));
	assign at_end   = (step_sum == {1'b0, cnt_q});
	assign hit      = (rdata == val_q);

	// sequencer
	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		ok_d     = ok_q;
		ovf_d    = ovf_q;
		taken_d  = taken_q;
		we       = 1'b0;
		waddr    = wr_ptr_q;
		wdata    = rdata;
		raddr    = inc_out;
		ready    = (state_q == ST_IDLE) || ((state_q == ST_DONE) && rsp_free);
		emit     = (state_q == ST_DONE) && rsp_free;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ok_d    = 1'b0;
				ovf_d   = 1'b0;
				taken_d = '0;
				state_d = ST_DONE;
				case (kind_q)
					bdq_pkg::REQ_PUSH_FRONT: begin
						if (full) begin
							ovf_d = 1'b1;
						end else begin
							we      = 1'b1;
							waddr   = front_dec;
							wdata   = val_q;
							front_d = front_dec;
							cnt_d   = cnt_q + CNT_W'(1);
							ok_d    = 1'b1;
						end
					end
					bdq_pkg::REQ_PUSH_BACK: begin
						if (full) begin
							ovf_d = 1'b1;
						end else begin
							we    = 1'b1;
							waddr = slot_out;
							wdata = val_q;
							cnt_d = cnt_q + CNT_W'(1);
							ok_d  = 1'b1;
						end
					end
					bdq_pkg::REQ_POP_FRONT: begin
						if (!empty) begin
							raddr   = front_q;
							state_d = ST_POP;
						end
					end
					bdq_pkg::REQ_POP_BACK: begin
						if (!empty) begin
							raddr   = slot_out;
							state_d = ST_POP;
						end
					end
					bdq_pkg::REQ_REMOVE, bdq_pkg::REQ_CONTAINS: begin
						if (!empty) begin
							raddr    = front_q;
							rd_ptr_d = front_q;
							idx_d    = '0;
							state_d  = ST_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			ST_POP: begin
				taken_d = rdata;
				ok_d    = 1'b1;
				cnt_d   = cnt_m1;
				if (kind_q == bdq_pkg::REQ_POP_FRONT) begin
					front_d = inc_out;
				end
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (hit) begin
					ok_d = 1'b1;
					if (kind_q == bdq_pkg::REQ_CONTAINS) begin
						state_d = ST_DONE;
					end else if (at_end) begin
						// match on the last entry: nothing to close up
						cnt_d   = cnt_m1;
						state_d = ST_DONE;
					end else begin
						wr_ptr_d = rd_ptr_q;
						rd_ptr_d = inc_out;
						state_d  = ST_SHIFT;
					end
				end else if (at_end) begin
					state_d = ST_DONE;
				end else begin
					rd_ptr_d = inc_out;
					idx_d    = idx_q + CNT_W'(1);
				end
			end
			ST_SHIFT: begin
				// move the entry behind the gap one place toward the front
				we       = 1'b1;
				waddr    = wr_ptr_q;
				wdata    = rdata;
				wr_ptr_d = rd_ptr_q;
				idx_d    = idx_q + CNT_W'(1);
				if (at_end) begin
					cnt_d   = cnt_m1;
					state_d = ST_DONE;
				end else begin
					rd_ptr_d = inc_out;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = start ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			cnt_q   <= cnt_d;
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= req_type;
			val_q  <= data_value[EW-1:0];
		end
		idx_q    <= idx_d;
		rd_ptr_q <= rd_ptr_d;
		wr_ptr_q <= wr_ptr_d;
		ok_q     <= ok_d;
		ovf_q    <= ovf_d;
		taken_q  <= taken_d;
	end

	// result of the finished transaction
	assign val_ext      = {{bdq_pkg::DATA_W{1'b0}}, taken_q};
	assign cnt_ext      = {{bdq_pkg::COUNT_W{1'b0}}, cnt_q};
	assign res.ok       = ok_q;
	assign res.value    = val_ext[bdq_pkg::DATA_W-1:0];
	assign res.count    = cnt_ext[bdq_pkg::COUNT_W-1:0];
	assign res.overflow = ovf_q;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of bounded_deque_with_remove
// depends on bdq_pkg and the block RTL; a directed table, a full-store burst, then random requests
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int DEPTH        = bdq_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 360;
	localparam int BLOCK_ITEMS  = 75;
	localparam int TIMEOUT_NS   = 5_000_000;

	// request codes outside the enum, answered as no-ops
	localparam logic [bdq_pkg::REQ_W-1:0] REQ_NOP_A = 3'd6;
	localparam logic [bdq_pkg::REQ_W-1:0] REQ_NOP_B = 3'd7;

	localparam bdq_pkg::rsp_t MISS_EMPTY = '{1'b0, 32'h0, 7'd0, 1'b0};
	localparam bdq_pkg::rsp_t NOT_TYPED  = '0;
	localparam bdq_pkg::rsp_t FULL_DROP  = '{1'b0, 32'h0, 7'(DEPTH), 1'b1};

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED} mix_t;

	typedef struct {
		logic [bdq_pkg::REQ_W-1:0]  kind;
		logic [bdq_pkg::DATA_W-1:0] val;
		bit                         fixed_want;
		bdq_pkg::rsp_t              want;
	} stim_row_t;

	// directed requests; a typed answer where it is obvious, else predicted
	stim_row_t directed_rows [0:23] = '{
		'{bdq_pkg::REQ_POP_FRONT,  32'hDEAD_BEEF, 1'b1, MISS_EMPTY},
		'{bdq_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, MISS_EMPTY},
		'{bdq_pkg::REQ_REMOVE,     32'h0000_0000, 1'b1, MISS_EMPTY},
		'{bdq_pkg::REQ_CONTAINS,   32'h0000_0000, 1'b1, MISS_EMPTY},
		'{REQ_NOP_A,               32'hFFFF_FFFF, 1'b1, MISS_EMPTY},
		'{REQ_NOP_B,               32'h0000_0000, 1'b1, MISS_EMPTY},
		'{bdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd1, 1'b0}},
		'{bdq_pkg::REQ_PUSH_BACK,  32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd2, 1'b0}},
		'{bdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, '{1'b1, 32'h0, 7'd3, 1'b0}},
		'{bdq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd4, 1'b0}},
		'{bdq_pkg::REQ_CONTAINS,   32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd4, 1'b0}},
		'{bdq_pkg::REQ_CONTAINS,   32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd4, 1'b0}},
		'{REQ_NOP_A,               32'h1234_5678, 1'b1, '{1'b0, 32'h0, 7'd4, 1'b0}},
		'{bdq_pkg::REQ_REMOVE,     32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd3, 1'b0}},
		'{bdq_pkg::REQ_REMOVE,     32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd3, 1'b0}},
		'{bdq_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 7'd2, 1'b0}},
		'{bdq_pkg::REQ_POP_FRONT,  32'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'h8000_0000, 7'd1, 1'b0}},
		'{bdq_pkg::REQ_PUSH_FRONT, 32'h0000_0001, 1'b1, '{1'b1, 32'h0, 7'd2, 1'b0}},
		'{bdq_pkg::REQ_REMOVE,     32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd1, 1'b0}},
		'{bdq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1,
			'{1'b1, 32'h0000_0001, 7'd0, 1'b0}},
		'{bdq_pkg::REQ_PUSH_BACK,  32'h5555_5555, 1'b0, NOT_TYPED},
		'{bdq_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, NOT_TYPED},
		'{bdq_pkg::REQ_REMOVE,     32'h5555_5555, 1'b0, NOT_TYPED},
		'{bdq_pkg::REQ_POP_FRONT,  32'h0F0F_0F0F, 1'b0, NOT_TYPED}
	};

	// values that recur often, so that duplicates sit in the store
	logic [bdq_pkg::DATA_W-1:0] common_values [0:3] =
		'{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};
	mix_t mix_plan [0:5] =
		'{MIX_SHRINK, MIX_GROW, MIX_MIXED, MIX_SHRINK, MIX_GROW, MIX_MIXED};

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         req_valid  = 1'b0;
	logic                         req_stall;
	logic [bdq_pkg::REQ_W-1:0]    req_type   = '0;
	logic [bdq_pkg::DATA_W-1:0]   data_value = '0;
	logic                         rsp_valid;
	logic                         rsp_stall  = 1'b0;
	logic                         ok;
	logic [bdq_pkg::DATA_W-1:0]   out_value;
	logic [bdq_pkg::COUNT_W-1:0]  count_now;
	logic                         overflow;

	// predictor state: held values from front to back
	logic [bdq_pkg::DATA_W-1:0] held [$];
	bdq_pkg::rsp_t              rsp_expected_q [$];
	int                         mismatch_count = 0;
	int                         rsp_seen       = 0;
	bit                         quiet          = 1'b0;

	bounded_deque_with_remove dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.data_value (data_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.ok         (ok),
		.out_value  (out_value),
		.count_now  (count_now),
		.overflow   (overflow)
	);

	always #CLK_HALF clk = ~clk;

	// apply one request to the held values and return its response
	function automatic bdq_pkg::rsp_t apply_request(input logic [bdq_pkg::REQ_W-1:0] kind,
			input logic [bdq_pkg::DATA_W-1:0] val);
		bdq_pkg::rsp_t r;
		int            hit;
		r   = '0;
		hit = -1;
		case (kind)
			bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
				if (held.size() >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					if (kind == bdq_pkg::REQ_PUSH_FRONT) held.push_front(val);
					else held.push_back(val);
					r.ok = 1'b1;
				end
			end
			bdq_pkg::REQ_POP_FRONT: begin
				if (held.size() != 0) begin
					r.value = held.pop_front();
					r.ok    = 1'b1;
				end
			end
			bdq_pkg::REQ_POP_BACK: begin
				if (held.size() != 0) begin
					r.value = held.pop_back();
					r.ok    = 1'b1;
				end
			end
			bdq_pkg::REQ_REMOVE, bdq_pkg::REQ_CONTAINS: begin
				// first occurrence from the front
				foreach (held[i]) if (hit < 0 && held[i] == val) hit = i;
				if (hit >= 0) begin
					r.ok = 1'b1;
					if (kind == bdq_pkg::REQ_REMOVE) held.delete(hit);
				end
			end
			default: begin
			end
		endcase
		r.count = bdq_pkg::COUNT_W'(held.size());
		return r;
	endfunction

	// request mix of the current random block
	function automatic logic [bdq_pkg::REQ_W-1:0] pick_kind(input mix_t mix);
		int push_pct, pop_pct, r;
		push_pct = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 10 : 35;
		pop_pct  = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 65 : 30;
		r = $urandom_range(99);
		if (r < push_pct)
			return $urandom_range(1) ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_BACK;
		if (r < push_pct + pop_pct)
			return $urandom_range(1) ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_POP_BACK;
		if (r < 96)
			return $urandom_range(1) ? bdq_pkg::REQ_REMOVE : bdq_pkg::REQ_CONTAINS;
		return $urandom_range(1) ? REQ_NOP_A : REQ_NOP_B;
	endfunction

	// searches mostly hit a held value; pushes sometimes repeat common values
	function automatic logic [bdq_pkg::DATA_W-1:0] pick_value(
			input logic [bdq_pkg::REQ_W-1:0] kind);
		int r;
		r = $urandom_range(99);
		if ((kind == bdq_pkg::REQ_REMOVE || kind == bdq_pkg::REQ_CONTAINS)
				&& held.size() != 0 && r < 60)
			return held[$urandom_range(held.size() - 1)];
		if (r < 80) return $urandom;
		return common_values[$urandom_range(3)];
	endfunction

	task automatic report_mismatch(input string what, input logic [bdq_pkg::DATA_W-1:0] got,
			input logic [bdq_pkg::DATA_W-1:0] want);
		$display("%0t: response %0d: %s got %h want %h", $realtime, rsp_seen, what, got, want);
		mismatch_count++;
	endtask

	// one request transaction; the expectation is queued once it is accepted
	task automatic send_request(input logic [bdq_pkg::REQ_W-1:0] kind,
			input logic [bdq_pkg::DATA_W-1:0] val, input bit fixed_want,
			input bdq_pkg::rsp_t want);
		bdq_pkg::rsp_t predicted;
		while (!quiet && $urandom_range(99) < 9) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= kind;
		data_value <= val;
		do @(posedge clk); while (req_stall);
		predicted = apply_request(kind, val);
		rsp_expected_q.push_back(fixed_want ? want : predicted);
	endtask

	// response side back-pressure
	always @(posedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < 9);
	end

	// response checker
	always @(posedge clk) begin
		bdq_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected_q.size() == 0) begin
				report_mismatch("response with none pending, count_now", 32'(count_now), '0);
			end else begin
				want = rsp_expected_q.pop_front();
				if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
				if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
				if (count_now !== want.count)
					report_mismatch("count_now", 32'(count_now), 32'(want.count));
				if (overflow !== want.overflow)
					report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
			end
			rsp_seen++;
		end
	end

	// stimulus
	initial begin
		logic [bdq_pkg::REQ_W-1:0] kind;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].kind, directed_rows[i].val,
				directed_rows[i].fixed_want, directed_rows[i].want);

		// fill from both ends so the front wraps, then push into the full store
		while (held.size() < DEPTH)
			send_request($urandom_range(1) ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_BACK,
				$urandom, 1'b0, NOT_TYPED);
		send_request(bdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, FULL_DROP);
		send_request(bdq_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1'b1, FULL_DROP);
		send_request(bdq_pkg::REQ_CONTAINS, held[DEPTH - 1], 1'b0, NOT_TYPED);
		send_request(bdq_pkg::REQ_REMOVE, held[DEPTH - 1], 1'b0, NOT_TYPED);
		send_request(bdq_pkg::REQ_REMOVE, held[0], 1'b0, NOT_TYPED);

		// random blocks that drain, fill and mix; one stretch runs without idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 200 && n < 300);
			kind  = pick_kind(mix_plan[(n / BLOCK_ITEMS) % 6]);
			send_request(kind, pick_value(kind), 1'b0, NOT_TYPED);
		end
		req_valid <= 1'b0;
		quiet = 1'b0;

		// drain outstanding responses, then wait with no requests before the report
		while (rsp_expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#TIMEOUT_NS;
		$display("timeout with %0d responses pending", rsp_expected_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
